// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the filter RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is released.
`define PCF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every rising edge, during reset as well.
`define PCF_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/pcf_pkg.sv =====
// Package of the periodic pair cutoff filter: payload structs, request codes,
// configuration indices and sizing constants. No dependencies.
`default_nettype none

package pcf_pkg;

	localparam int BEAD_W    = 10;
	localparam int MAX_BEADS = 1024;
	localparam int SLOT_W    = 16;
	localparam logic [SLOT_W-1:0] SLOT_CAP = 16'hFFFF;
	localparam int QUEUE_DEPTH = 4;
	localparam int OUT_DEPTH   = 8;

	localparam logic [1:0] REQ_LOAD_POS   = 2'd0;
	localparam logic [1:0] REQ_LOAD_SIGMA = 2'd1;
	localparam logic [1:0] REQ_TEST_ATTR  = 2'd2;
	localparam logic [1:0] REQ_TEST_REP   = 2'd3;

	localparam logic CFG_BOX_LENGTH = 1'b0;
	localparam logic CFG_INV_BOX    = 1'b1;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [BEAD_W-1:0] bead_a;
		logic [BEAD_W-1:0] bead_b;
		logic [1:0]        type_a;
		logic [1:0]        type_b;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
		logic [30:0]       ref_dist;
		logic              new_pass;
	} request_t;

	typedef struct packed {
		logic              kept;
		logic              list_kind;
		logic [SLOT_W-1:0] slot;
		logic [BEAD_W-1:0] pair_bead_a;
		logic [BEAD_W-1:0] pair_bead_b;
		logic [1:0]        pair_type_a;
		logic [1:0]        pair_type_b;
		logic [30:0]       pair_ref_dist;
		logic              list_full;
	} result_t;

	typedef struct packed {
		logic [BEAD_W-1:0] bead_a;
		logic [BEAD_W-1:0] bead_b;
		logic [1:0]        type_a;
		logic [1:0]        type_b;
		logic [30:0]       ref_dist;
		logic              rep;
		logic              new_pass;
	} pair_meta_t;

	typedef struct packed {
		pair_meta_t         meta;
		logic [30:0]        cut_ref;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [32:0] dz;
	} pair_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/pcf_front.sv =====
// Front end: accepts requests, serves loads into the position and sigma
// stores, and turns tests into coordinate differences. Uses pcf_pkg.
`default_nettype none

module pcf_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire pcf_pkg::request_t  request,
	output logic                    q_wr,
	output pcf_pkg::pair_item_t     q_data,
	input  wire logic               q_full
);
	import pcf_pkg::*;

	logic [31:0] pos_x_mem [MAX_BEADS];
	logic [31:0] pos_y_mem [MAX_BEADS];
	logic [31:0] pos_z_mem [MAX_BEADS];
	logic [30:0] sigma_q [16];

	logic        vld_s1;
	pair_meta_t  meta_s1;
	logic [30:0] cut_s1;
	logic [31:0] xa_s1, ya_s1, za_s1, xb_s1, yb_s1, zb_s1;
	logic        accept, is_test;

	assign accept  = push && !full;
	assign is_test = request.req_type == REQ_TEST_ATTR || request.req_type == REQ_TEST_REP;
	assign full    = vld_s1 && q_full;
	assign q_wr    = vld_s1 && !q_full;

	always_ff @(posedge clk) begin
		if (accept && request.req_type == REQ_LOAD_POS) begin
			pos_x_mem[request.bead_a] <= request.coord_x;
			pos_y_mem[request.bead_a] <= request.coord_y;
			pos_z_mem[request.bead_a] <= request.coord_z;
		end
		if (accept && request.req_type == REQ_LOAD_SIGMA) begin
			sigma_q[{request.type_a, request.type_b}] <= request.ref_dist;
		end
		if (accept && is_test) begin
			xa_s1 <= pos_x_mem[request.bead_a];
			ya_s1 <= pos_y_mem[request.bead_a];
			za_s1 <= pos_z_mem[request.bead_a];
			xb_s1 <= pos_x_mem[request.bead_b];
			yb_s1 <= pos_y_mem[request.bead_b];
			zb_s1 <= pos_z_mem[request.bead_b];
			meta_s1.bead_a   <= request.bead_a;
			meta_s1.bead_b   <= request.bead_b;
			meta_s1.type_a   <= request.type_a;
			meta_s1.type_b   <= request.type_b;
			meta_s1.ref_dist <= request.ref_dist;
			meta_s1.rep      <= request.req_type == REQ_TEST_REP;
			meta_s1.new_pass <= request.new_pass;
			cut_s1 <= (request.req_type == REQ_TEST_REP)
				? sigma_q[{request.type_a, request.type_b}] : request.ref_dist;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept && is_test) begin
			vld_s1 <= 1'b1;
		end else if (q_wr) begin
			vld_s1 <= 1'b0;
		end
	end

	always_comb begin
		q_data.meta    = meta_s1;
		q_data.cut_ref = cut_s1;
		q_data.dx = $signed({xb_s1[31], xb_s1}) - $signed({xa_s1[31], xa_s1});
		q_data.dy = $signed({yb_s1[31], yb_s1}) - $signed({ya_s1[31], ya_s1});
		q_data.dz = $signed({zb_s1[31], zb_s1}) - $signed({za_s1[31], za_s1});
	end

endmodule

`default_nettype wire

// ===== rtl/core/pcf_queue.sv =====
// Short queue of pair tests between the front end and the back end.
// Uses pcf_pkg.
`default_nettype none

module pcf_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr,
	input  wire pcf_pkg::pair_item_t wr_data,
	output logic                     full,
	input  wire logic                rd,
	output pcf_pkg::pair_item_t      rd_data,
	output logic                     empty
);
	import pcf_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	pair_item_t    mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   cnt_q;

	assign full    = cnt_q == (PW+1)'(QUEUE_DEPTH);
	assign empty   = cnt_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr && !full) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(wr && !full) - (PW+1)'(rd && !empty);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/pcf_back.sv =====
// Back end: minimum-image reduction, squared distance against the squared
// cutoff, list slot counters and the result buffer. Uses pcf_pkg.
`default_nettype none

module pcf_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_empty,
	output logic                     q_rd,
	input  wire pcf_pkg::pair_item_t q_data,
	input  wire logic [30:0]         box_length,
	input  wire logic [31:0]         inverse_box_length,
	output logic                     empty,
	input  wire logic                pop,
	output pcf_pkg::result_t         result
);
	import pcf_pkg::*;

	localparam int OW = $clog2(OUT_DEPTH);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	pair_meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_s6;
	logic [32:0] mag_s1 [3];
	logic [32:0] mag_s2 [3];
	logic [32:0] mag_s3 [3];
	logic [16:0] ptop_s2 [3];
	logic [47:0] corr_s3 [3];
	logic [33:0] c_s4 [3];
	logic [67:0] sq_s5 [3];
	logic [30:0] ref_s1;
	logic [61:0] refsq_s2, refsq_s3;
	logic [66:0] rhs_s4, rhs_s5;
	logic        kept_s6;

	logic [2:0]  inflight;
	logic [32:0] d_in [3];

	logic [SLOT_W-1:0] att_cnt_q, rep_cnt_q;
	logic [SLOT_W-1:0] base_att, base_rep, cur, next_cnt;
	result_t res_w;

	result_t     out_mem_q [OUT_DEPTH];
	logic [OW-1:0] out_wr_q, out_rd_q;
	logic [OW:0] out_cnt_q;

	assign inflight = 3'(v_s1) + 3'(v_s2) + 3'(v_s3) + 3'(v_s4) + 3'(v_s5) + 3'(v_s6);
	assign q_rd = !q_empty && ((OW+1)'(out_cnt_q + (OW+1)'(inflight)) < (OW+1)'(OUT_DEPTH));

	assign d_in[0] = q_data.dx;
	assign d_in[1] = q_data.dy;
	assign d_in[2] = q_data.dz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= q_rd;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		logic [64:0] prod;
		logic [16:0] n;
		logic [47:0] magx, r;
		logic [69:0] sum;
		for (int i = 0; i < 3; i++) begin
			mag_s1[i]  <= d_in[i][32] ? (~d_in[i] + 33'd1) : d_in[i];
			prod        = 65'(mag_s1[i]) * 65'(inverse_box_length);
			ptop_s2[i] <= prod[63:47];
			mag_s2[i]  <= mag_s1[i];
			n           = {1'b0, ptop_s2[i][16:1]} + 17'(ptop_s2[i][0]);
			corr_s3[i] <= 48'(n) * 48'(box_length);
			mag_s3[i]  <= mag_s2[i];
			magx        = 48'(mag_s3[i]);
			r           = (magx >= corr_s3[i]) ? magx - corr_s3[i] : corr_s3[i] - magx;
			c_s4[i]    <= (r > 48'h2_0000_0000) ? 34'h2_0000_0000 : r[33:0];
			sq_s5[i]   <= 68'(c_s4[i]) * 68'(c_s4[i]);
		end
		meta_s1  <= q_data.meta;
		ref_s1   <= q_data.cut_ref;
		meta_s2  <= meta_s1;
		refsq_s2 <= 62'(ref_s1) * 62'(ref_s1);
		meta_s3  <= meta_s2;
		refsq_s3 <= refsq_s2;
		meta_s4  <= meta_s3;
		rhs_s4   <= (67'(refsq_s3) << 4) + (67'(refsq_s3) << 3) + 67'(refsq_s3);
		meta_s5  <= meta_s4;
		rhs_s5   <= rhs_s4;
		sum       = 70'(sq_s5[0]) + 70'(sq_s5[1]) + 70'(sq_s5[2]);
		meta_s6  <= meta_s5;
		kept_s6  <= {sum, 2'b00} < 72'(rhs_s5);
	end

	always_comb begin
		base_att = meta_s6.new_pass ? '0 : att_cnt_q;
		base_rep = meta_s6.new_pass ? '0 : rep_cnt_q;
		cur      = meta_s6.rep ? base_rep : base_att;
		next_cnt = cur;
		res_w.kept          = kept_s6;
		res_w.list_kind     = meta_s6.rep;
		res_w.slot          = '0;
		res_w.list_full     = 1'b0;
		res_w.pair_bead_a   = meta_s6.bead_a;
		res_w.pair_bead_b   = meta_s6.bead_b;
		res_w.pair_type_a   = meta_s6.type_a;
		res_w.pair_type_b   = meta_s6.type_b;
		res_w.pair_ref_dist = meta_s6.rep ? '0 : meta_s6.ref_dist;
		if (kept_s6) begin
			if (cur >= SLOT_CAP) begin
				res_w.list_full = 1'b1;
				res_w.slot      = SLOT_CAP;
			end else begin
				next_cnt   = cur + 1'b1;
				res_w.slot = next_cnt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			att_cnt_q <= '0;
			rep_cnt_q <= '0;
		end else if (v_s6) begin
			att_cnt_q <= meta_s6.rep ? base_att : next_cnt;
			rep_cnt_q <= meta_s6.rep ? next_cnt : base_rep;
		end
	end

	assign empty  = out_cnt_q == '0;
	assign result = out_mem_q[out_rd_q];

	always_ff @(posedge clk) begin
		if (v_s6) begin
			out_mem_q[out_wr_q] <= res_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= '0;
			out_rd_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (v_s6) begin
				out_wr_q <= out_wr_q + 1'b1;
			end
			if (pop && !empty) begin
				out_rd_q <= out_rd_q + 1'b1;
			end
			out_cnt_q <= out_cnt_q + (OW+1)'(v_s6) - (OW+1)'(pop && !empty);
		end
	end

	`include "assert_macros.svh"

	`PCF_ASSERT(a_out_room, (out_cnt_q + (OW+1)'(inflight)) <= (OW+1)'(OUT_DEPTH), "result buffer overbooked")
	`PCF_ASSERT(a_full_slot, !(v_s6 && res_w.list_full) || (res_w.kept && res_w.slot == SLOT_CAP), "saturated slot wrong")
	`PCF_ASSERT(a_slot_kept, !v_s6 || ((res_w.slot != '0) == res_w.kept), "slot given without keep")

endmodule

`default_nettype wire

// ===== rtl/core/periodic_pair_cutoff_filter_unit.sv =====
// Top level of the periodic pair cutoff filter: configuration registers and
// the front end, queue and back end. Uses pcf_pkg and the pcf_* modules.
//
// Channel   Direction  Handshake        Payload
// request   in         push / full      pcf_pkg::request_t
// result    out        empty / pop      pcf_pkg::result_t
// config    in         cfg_we           cfg_index, cfg_data
//
// One request is taken per cycle while full is low; loads give no result.
// A test reaches the result buffer through one front register, the queue and
// the six-stage arithmetic pipeline.
// The back end issues only while the eight-entry result buffer has room for
// every test in flight, so a stalled consumer backs up into full.
// Reset clears counters, pointers and valid bits; the stores are not cleared.
`default_nettype none

module periodic_pair_cutoff_filter_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire pcf_pkg::request_t request,
	output logic                   empty,
	input  wire logic              pop,
	output pcf_pkg::result_t       result,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [31:0]       cfg_data
);
	import pcf_pkg::*;

	logic [30:0] box_q;
	logic [31:0] inv_q;
	logic        q_wr, q_full, q_rd, q_empty;
	pair_item_t  q_in, q_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= 31'd65536000;
			inv_q <= 32'd4294967;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BOX_LENGTH: box_q <= cfg_data[30:0];
				CFG_INV_BOX:    inv_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pcf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.request (request),
		.q_wr    (q_wr),
		.q_data  (q_in),
		.q_full  (q_full)
	);

	pcf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_in),
		.full    (q_full),
		.rd      (q_rd),
		.rd_data (q_out),
		.empty   (q_empty)
	);

	pcf_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.q_empty            (q_empty),
		.q_rd               (q_rd),
		.q_data             (q_out),
		.box_length         (box_q),
		.inverse_box_length (inv_q),
		.empty              (empty),
		.pop                (pop),
		.result             (result)
	);

endmodule

`default_nettype wire
